/* hw/rtl/pbl_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes, types and saturation helper for the patch sample blender.
// No dependencies; used by the interfaces, the divider and the top level.
package pbl_pkg;

   localparam int SAMPLE_W      = 32;
   localparam int FRAC_BITS_DEF = 24;
   localparam int MODE_W        = 3;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 3;
   localparam int DIV_STEP      = 4;
   localparam int DIV_STAGES    = SAMPLE_W / DIV_STEP;

   localparam logic [MODE_W-1:0] MODE_NONE         = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REPLACE      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ADD          = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MUL          = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BLEND_ABOVE  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_BLEND_BELOW  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_MULADD_ABOVE = 3'd6;
   localparam logic [MODE_W-1:0] MODE_MULADD_BELOW = 3'd7;

   localparam logic [CSR_IDX_W-1:0] REG_BLEND_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLAMP_ENABLE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PREMULTIPLIED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_ALPHA = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_PRESENT = 3'd4;

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   typedef struct packed {
      logic                       valid;
      logic                       is_div;
      logic                       neg;
      logic                       ovf;
      logic                       zero;
      logic [SAMPLE_W-1:0]        quot;
      logic signed [SAMPLE_W-1:0] res;
   } pbl_div_out_type;

   function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v;
      if (v > S32_MAX) t = S32_MAX;
      if (v < S32_MIN) t = S32_MIN;
      return t[SAMPLE_W-1:0];
   endfunction

endpackage

/* hw/rtl/pbl_req_if.sv */
`timescale 1ns / 1ps
// Request channel: base and new samples with their alpha, valid/ready handshake.
// Depends on pbl_pkg for the sample width.
interface pbl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pbl_pkg::SAMPLE_W-1:0]  base_sample;
   logic signed [pbl_pkg::SAMPLE_W-1:0]  new_sample;
   logic signed [pbl_pkg::SAMPLE_W-1:0]  canvas_alpha;
   logic signed [pbl_pkg::SAMPLE_W-1:0]  ref_alpha;

   modport source (output valid, base_sample, new_sample, canvas_alpha, ref_alpha,
                   input ready);
   modport sink   (input valid, base_sample, new_sample, canvas_alpha, ref_alpha,
                   output ready);
endinterface

/* hw/rtl/pbl_rsp_if.sv */
`timescale 1ns / 1ps
// Response channel: blended sample, valid/ready handshake.
// Depends on pbl_pkg for the sample width.
interface pbl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pbl_pkg::SAMPLE_W-1:0]  blended_sample;

   modport source (output valid, blended_sample, input ready);
   modport sink   (input valid, blended_sample, output ready);
endinterface

/* hw/rtl/pbl_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: (|numer| << FRAC_BITS) / mixed, four quotient bits per stage.
// Depends on pbl_pkg.
module pbl_div #(
   parameter int FRAC_BITS = pbl_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic                                 in_is_div,
   input  logic signed [pbl_pkg::SAMPLE_W-1:0]  in_numer,
   input  logic signed [pbl_pkg::SAMPLE_W-1:0]  in_mixed,
   input  logic signed [pbl_pkg::SAMPLE_W-1:0]  in_res,
   output pbl_pkg::pbl_div_out_type             out
);
   localparam int W  = pbl_pkg::SAMPLE_W;
   localparam int NS = pbl_pkg::DIV_STAGES;
   localparam int ST = pbl_pkg::DIV_STEP;

   logic [NS:0]         v_ff;
   logic [NS:0]         isdiv_ff;
   logic [NS:0]         neg_ff;
   logic [NS:0]         ovf_ff;
   logic [NS:0]         zero_ff;
   logic [W-1:0]        r_ff   [0:NS];
   logic [W-1:0]        q_ff   [0:NS];
   logic [W-2:0]        m_ff   [0:NS];
   logic signed [W-1:0] res_ff [0:NS];
   logic [W-1:0]        r_in   [1:NS];
   logic [W-1:0]        q_in   [1:NS];

   // front: take magnitude, shift up, check for quotient overflow
   logic [W-1:0]   abs_num;
   logic [2*W-1:0] dvd;
   always_comb begin
      abs_num = in_numer[W-1] ? (~in_numer + 1'b1) : in_numer;
      dvd     = (2*W)'(abs_num) << FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         isdiv_ff[0] <= in_is_div;
         neg_ff[0]   <= in_numer[W-1];
         zero_ff[0]  <= (in_mixed[W-1] || (in_mixed == '0));
         ovf_ff[0]   <= (dvd[2*W-1:W] >= W'(in_mixed[W-2:0]));
         r_ff[0]     <= dvd[2*W-1:W];
         q_ff[0]     <= dvd[W-1:0];
         m_ff[0]     <= in_mixed[W-2:0];
         res_ff[0]   <= in_res;
      end
   end

   // each stage retires ST quotient bits; dividend low bits shift out as quotient shifts in
   always_comb begin
      logic [W:0]   rem;
      logic [W-1:0] rr;
      logic [W-1:0] qq;
      for (int k = 1; k <= NS; k++) begin
         rr = r_ff[k-1];
         qq = q_ff[k-1];
         for (int s = 0; s < ST; s++) begin
            rem = {rr, qq[W-1]};
            qq  = {qq[W-2:0], 1'b0};
            if (rem >= (W+1)'(m_ff[k-1])) begin
               rem   = rem - (W+1)'(m_ff[k-1]);
               qq[0] = 1'b1;
            end
            rr = rem[W-1:0];
         end
         r_in[k] = rr;
         q_in[k] = qq;
      end
   end

   for (genvar k = 1; k <= NS; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (en) begin
            isdiv_ff[k] <= isdiv_ff[k-1];
            neg_ff[k]   <= neg_ff[k-1];
            ovf_ff[k]   <= ovf_ff[k-1];
            zero_ff[k]  <= zero_ff[k-1];
            m_ff[k]     <= m_ff[k-1];
            res_ff[k]   <= res_ff[k-1];
            r_ff[k]     <= r_in[k];
            q_ff[k]     <= q_in[k];
         end
      end
   end

   always_comb begin
      out.valid  = v_ff[NS];
      out.is_div = isdiv_ff[NS];
      out.neg    = neg_ff[NS];
      out.ovf    = ovf_ff[NS];
      out.zero   = zero_ff[NS];
      out.quot   = q_ff[NS];
      out.res    = res_ff[NS];
   end
endmodule

/* hw/rtl/patch_sample_blender.sv */
`timescale 1ns / 1ps
// Patch sample blender: per-sample compositor, eight blend modes, signed fixed point.
// Registers from request beat to response beat: 5 arithmetic stages, divider entry,
// 8 divider stages of 4 quotient bits, output register.
// Throughput: one beat per cycle; a stalled response freezes the whole pipe.
// Reset (synchronous, active high) clears all valid bits and the config registers.
// Depends on pbl_pkg, pbl_req_if, pbl_rsp_if and pbl_div.
module patch_sample_blender #(
   parameter int FRAC_BITS = pbl_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   pbl_req_if.sink                               req,
   pbl_rsp_if.source                             rsp,
   input  logic                                  csr_write_enable,
   input  logic [pbl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pbl_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   localparam int W = pbl_pkg::SAMPLE_W;
   localparam logic signed [63:0] ONE_Q  = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic [1:0] KIND_DIRECT = 2'd0;
   localparam logic [1:0] KIND_PROD   = 2'd1;
   localparam logic [1:0] KIND_DIV    = 2'd2;

   // round to nearest (ties up) after the fixed-point product, then saturate
   function automatic logic signed [W-1:0] qround(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + HALF_Q) >>> FRAC_BITS;
      return pbl_pkg::sat32(t);
   endfunction

   function automatic logic signed [W-1:0] unit_clamp(input logic signed [W-1:0] v);
      logic signed [W-1:0] t;
      t = v;
      if (v < 0) t = '0;
      if (64'(v) > ONE_Q) t = ONE_Q[W-1:0];
      return t;
   endfunction

   function automatic logic signed [W-1:0] one_minus(input logic signed [W-1:0] v);
      return pbl_pkg::sat32(ONE_Q - 64'(v));
   endfunction

   // ---------------- configuration registers ----------------
   logic [pbl_pkg::MODE_W-1:0] mode_ff;
   logic clamp_ff, premul_ff, is_alpha_ff, alpha_pres_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= pbl_pkg::MODE_NONE;
         clamp_ff      <= 1'b0;
         premul_ff     <= 1'b0;
         is_alpha_ff   <= 1'b0;
         alpha_pres_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            pbl_pkg::REG_BLEND_MODE:    mode_ff       <= csr_write_data[pbl_pkg::MODE_W-1:0];
            pbl_pkg::REG_CLAMP_ENABLE:  clamp_ff      <= csr_write_data[0];
            pbl_pkg::REG_PREMULTIPLIED: premul_ff     <= csr_write_data[0];
            pbl_pkg::REG_CHANNEL_ALPHA: is_alpha_ff   <= csr_write_data[0];
            pbl_pkg::REG_ALPHA_PRESENT: alpha_pres_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // One enable for every stage: advance unless the output beat is held.
   logic en;
   logic out_v_ff;
   assign en        = !out_v_ff || rsp.ready;
   assign req.ready = en;

   // ---------------- stage 1: mode decode, operand select ----------------
   logic [1:0]          kind_in;
   logic signed [W-1:0] a0_in, b0_in, a1_in, b1_in, a2_in, b2_in, add_in, dir_in, nar_in;

   always_comb begin
      logic [pbl_pkg::MODE_W-1:0] m;
      logic                below;
      logic signed [W-1:0] bs, ns, ba, na, hic;
      m     = mode_ff;
      below = (mode_ff == pbl_pkg::MODE_BLEND_BELOW) || (mode_ff == pbl_pkg::MODE_MULADD_BELOW);
      // with neither an alpha channel nor a reference alpha plane, blend falls back to replace and muladd to add
      if (!is_alpha_ff && !alpha_pres_ff) begin
         if (m == pbl_pkg::MODE_BLEND_ABOVE || m == pbl_pkg::MODE_BLEND_BELOW)
            m = pbl_pkg::MODE_REPLACE;
         else if (m == pbl_pkg::MODE_MULADD_ABOVE || m == pbl_pkg::MODE_MULADD_BELOW)
            m = pbl_pkg::MODE_ADD;
      end
      bs  = below ? req.new_sample   : req.base_sample;
      ns  = below ? req.base_sample  : req.new_sample;
      ba  = below ? req.ref_alpha    : req.canvas_alpha;
      na  = below ? req.canvas_alpha : req.ref_alpha;
      hic = clamp_ff ? unit_clamp(ns) : ns;
      if (clamp_ff) na = unit_clamp(na);
      nar_in  = one_minus(na);
      kind_in = KIND_DIRECT;
      dir_in  = req.base_sample;
      add_in  = '0;
      a0_in   = '0;
      b0_in   = '0;
      a1_in   = na;
      b1_in   = ns;
      a2_in   = ba;
      b2_in   = bs;
      case (m)
         pbl_pkg::MODE_REPLACE: dir_in = req.new_sample;
         pbl_pkg::MODE_ADD:
            dir_in = pbl_pkg::sat32(64'(req.base_sample) + 64'(req.new_sample));
         pbl_pkg::MODE_MUL: begin
            kind_in = KIND_PROD;
            a0_in   = req.base_sample;
            b0_in   = clamp_ff ? unit_clamp(req.new_sample) : req.new_sample;
         end
         pbl_pkg::MODE_BLEND_ABOVE, pbl_pkg::MODE_BLEND_BELOW: begin
            kind_in = KIND_PROD;
            if (is_alpha_ff) begin
               // lo + hi * (1 - lo)
               a0_in  = hic;
               b0_in  = one_minus(bs);
               add_in = bs;
            end else if (premul_ff) begin
               a0_in  = bs;
               b0_in  = nar_in;
               add_in = ns;
            end else begin
               // straight alpha: mixed alpha first, weighted sum later, then divide
               kind_in = KIND_DIV;
               a0_in   = nar_in;
               b0_in   = one_minus(ba);
            end
         end
         pbl_pkg::MODE_MULADD_ABOVE, pbl_pkg::MODE_MULADD_BELOW: begin
            if (is_alpha_ff) begin
               dir_in = bs;
            end else begin
               kind_in = KIND_PROD;
               a0_in   = na;
               b0_in   = ns;
               add_in  = bs;
            end
         end
         default: dir_in = req.base_sample;
      endcase
   end

   logic                s1_v_ff;
   logic [1:0]          s1_kind_ff;
   logic signed [W-1:0] s1_a0_ff, s1_b0_ff, s1_a1_ff, s1_b1_ff, s1_a2_ff, s1_b2_ff;
   logic signed [W-1:0] s1_add_ff, s1_dir_ff, s1_nar_ff;

   // ---------------- stage 2: three raw products ----------------
   logic                s2_v_ff;
   logic [1:0]          s2_kind_ff;
   logic signed [63:0]  s2_p0_ff, s2_p1_ff, s2_p2_ff;
   logic signed [W-1:0] s2_add_ff, s2_dir_ff, s2_nar_ff;

   // ---------------- stage 3: round, combine ----------------
   logic signed [W-1:0] r0, r1, r2;
   always_comb begin
      r0 = qround(s2_p0_ff);
      r1 = qround(s2_p1_ff);
      r2 = qround(s2_p2_ff);
   end
   logic                s3_v_ff;
   logic                s3_div_ff;
   logic signed [W-1:0] s3_res_ff, s3_mixed_ff, s3_r1_ff, s3_r2_ff, s3_nar_ff;

   // ---------------- stage 4: product ba*bs by (1 - na) ----------------
   logic                s4_v_ff;
   logic                s4_div_ff;
   logic signed [63:0]  s4_p3_ff;
   logic signed [W-1:0] s4_res_ff, s4_mixed_ff, s4_r1_ff;

   // ---------------- stage 5: numerator ----------------
   logic                s5_v_ff;
   logic                s5_div_ff;
   logic signed [W-1:0] s5_res_ff, s5_mixed_ff, s5_numer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req.valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
      if (en) begin
         s1_kind_ff  <= kind_in;
         s1_a0_ff    <= a0_in;
         s1_b0_ff    <= b0_in;
         s1_a1_ff    <= a1_in;
         s1_b1_ff    <= b1_in;
         s1_a2_ff    <= a2_in;
         s1_b2_ff    <= b2_in;
         s1_add_ff   <= add_in;
         s1_dir_ff   <= dir_in;
         s1_nar_ff   <= nar_in;

         s2_kind_ff  <= s1_kind_ff;
         s2_p0_ff    <= 64'(s1_a0_ff) * 64'(s1_b0_ff);
         s2_p1_ff    <= 64'(s1_a1_ff) * 64'(s1_b1_ff);
         s2_p2_ff    <= 64'(s1_a2_ff) * 64'(s1_b2_ff);
         s2_add_ff   <= s1_add_ff;
         s2_dir_ff   <= s1_dir_ff;
         s2_nar_ff   <= s1_nar_ff;

         s3_div_ff   <= (s2_kind_ff == KIND_DIV);
         s3_res_ff   <= (s2_kind_ff == KIND_PROD) ?
                        pbl_pkg::sat32(64'(s2_add_ff) + 64'(r0)) : s2_dir_ff;
         s3_mixed_ff <= one_minus(r0);
         s3_r1_ff    <= r1;
         s3_r2_ff    <= r2;
         s3_nar_ff   <= s2_nar_ff;

         s4_div_ff   <= s3_div_ff;
         s4_p3_ff    <= 64'(s3_r2_ff) * 64'(s3_nar_ff);
         s4_res_ff   <= s3_res_ff;
         s4_mixed_ff <= s3_mixed_ff;
         s4_r1_ff    <= s3_r1_ff;

         s5_div_ff   <= s4_div_ff;
         s5_res_ff   <= s4_res_ff;
         s5_mixed_ff <= s4_mixed_ff;
         s5_numer_ff <= pbl_pkg::sat32(64'(s4_r1_ff) + 64'(qround(s4_p3_ff)));
      end
   end

   // ---------------- divider: numer * 2^FRAC_BITS / mixed ----------------
   pbl_pkg::pbl_div_out_type dv;

   pbl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_v_ff),
      .in_is_div (s5_div_ff),
      .in_numer  (s5_numer_ff),
      .in_mixed  (s5_mixed_ff),
      .in_res    (s5_res_ff),
      .out       (dv)
   );

   // ---------------- output register: sign, saturate, select ----------------
   logic signed [W-1:0] final_in;
   logic signed [W-1:0] out_data_ff;
   localparam logic [W-1:0] MIN_MAG = {1'b1, {(W-1){1'b0}}};

   always_comb begin
      if (!dv.is_div) begin
         final_in = dv.res;
      end else if (dv.zero) begin
         final_in = '0;
      end else if (dv.neg) begin
         final_in = (dv.ovf || dv.quot > MIN_MAG) ? MIN_MAG : (~dv.quot + 1'b1);
      end else begin
         final_in = (dv.ovf || dv.quot[W-1]) ? ~MIN_MAG : dv.quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= dv.valid;
      end
      if (en) begin
         out_data_ff <= final_in;
      end
   end

   assign rsp.valid          = out_v_ff;
   assign rsp.blended_sample = out_data_ff;

`ifndef ASSERT_OFF
   // hold the last arithmetic stage while the response is stalled
   a_s5_hold: assert property (@(posedge clock) disable iff (reset)
      (s5_v_ff && !en) |=> (s5_v_ff && $stable(s5_numer_ff)))
      else $error("stage 5 beat lost during stall");

   // a straight blend with no mixed alpha must give zero
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (en && dv.valid && dv.is_div && dv.zero) |=> (rsp.blended_sample == '0))
      else $error("zero mixed alpha did not give zero");

   // positive quotient overflow saturates high
   a_div_sat: assert property (@(posedge clock) disable iff (reset)
      (en && dv.valid && dv.is_div && !dv.zero && !dv.neg && dv.ovf)
      |=> (rsp.blended_sample == ~MIN_MAG))
      else $error("quotient overflow not saturated");
`endif
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for patch_sample_blender: drives sample beats under many
// register settings and compares every blended sample with a built-in predictor.
// Depends on pbl_pkg, pbl_req_if, pbl_rsp_if and the RTL of the blender.
module tb;

   localparam int FRAC     = pbl_pkg::FRAC_BITS_DEF;
   localparam int LATENCY  = 15;
   localparam longint ONE_Q  = 64'sd1 <<< FRAC;
   localparam longint HALF_Q = 64'sd1 <<< (FRAC - 1);
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [31:0] base_s;
      logic signed [31:0] new_s;
      logic signed [31:0] base_a;
      logic signed [31:0] new_a;
   } sample_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [pbl_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pbl_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   pbl_req_if req_ch ();
   pbl_rsp_if rsp_ch ();

   patch_sample_blender u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch.sink),
      .rsp              (rsp_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // Predictor copy of the register file.
   logic [2:0] cfg_mode;
   logic       cfg_clamp, cfg_premul, cfg_is_alpha, cfg_has_alpha;

   sample_beat_type    pending_beats[$];
   logic signed [31:0] expected_blend[$];

   // Set at the rising edge that took the presented request beat.
   logic req_taken = 1'b0;

   int  sender_idle_pct = 0;
   int  receiver_stall_pct = 0;
   int  mismatches = 0;
   int  beats_sent = 0;
   int  beats_checked = 0;
   longint cycles = 0;

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Rounded fixed-point product, ties up; >>> on a signed value is a floor.
   function automatic longint fx_mul(longint a, longint b);
      return clip32((a * b + HALF_Q) >>> FRAC);
   endfunction

   function automatic longint unit_clip(longint v);
      if (v < 0) return 0;
      if (v > ONE_Q) return ONE_Q;
      return v;
   endfunction

   function automatic logic signed [31:0] blend_sample(sample_beat_type s);
      longint b, n, ba_in, na_in, r, lo, hi, bs, ns, ba, na, nar, bar, mixed, numer;
      logic [2:0] mode;
      logic below;
      b = s.base_s; n = s.new_s; ba_in = s.base_a; na_in = s.new_a;
      mode = cfg_mode;
      below = (mode == pbl_pkg::MODE_BLEND_BELOW) || (mode == pbl_pkg::MODE_MULADD_BELOW);
      // With neither an alpha channel nor an alpha plane, blend falls back to replace and muladd to add.
      if (!cfg_is_alpha && !cfg_has_alpha) begin
         if (mode == pbl_pkg::MODE_BLEND_ABOVE || mode == pbl_pkg::MODE_BLEND_BELOW)
            mode = pbl_pkg::MODE_REPLACE;
         else if (mode == pbl_pkg::MODE_MULADD_ABOVE || mode == pbl_pkg::MODE_MULADD_BELOW)
            mode = pbl_pkg::MODE_ADD;
      end
      r = b;
      case (mode)
         pbl_pkg::MODE_REPLACE: r = n;
         pbl_pkg::MODE_ADD: r = clip32(b + n);
         pbl_pkg::MODE_MUL: r = fx_mul(b, cfg_clamp ? unit_clip(n) : n);
         pbl_pkg::MODE_BLEND_ABOVE, pbl_pkg::MODE_BLEND_BELOW: begin
            if (cfg_is_alpha) begin
               lo = below ? n : b;
               hi = below ? b : n;
               if (cfg_clamp) hi = unit_clip(hi);
               r = clip32(lo + fx_mul(hi, clip32(ONE_Q - lo)));
            end else begin
               bs = below ? n : b;
               ns = below ? b : n;
               ba = below ? na_in : ba_in;
               na = below ? ba_in : na_in;
               if (cfg_clamp) na = unit_clip(na);
               nar = clip32(ONE_Q - na);
               if (cfg_premul) begin
                  r = clip32(ns + fx_mul(bs, nar));
               end else begin
                  bar   = clip32(ONE_Q - ba);
                  mixed = clip32(ONE_Q - fx_mul(nar, bar));
                  numer = clip32(fx_mul(na, ns) + fx_mul(fx_mul(ba, bs), nar));
                  // Non-positive coverage gives zero; quotient truncates toward zero.
                  r = (mixed > 0) ? clip32((numer * ONE_Q) / mixed) : 0;
               end
            end
         end
         pbl_pkg::MODE_MULADD_ABOVE, pbl_pkg::MODE_MULADD_BELOW: begin
            if (cfg_is_alpha) begin
               r = below ? n : b;
            end else begin
               bs = below ? n : b;
               ns = below ? b : n;
               na = below ? ba_in : na_in;
               if (cfg_clamp) na = unit_clip(na);
               r = clip32(bs + fx_mul(na, ns));
            end
         end
         default: r = b;
      endcase
      return r[31:0];
   endfunction

   // Driver: present the head of the queue, advance on an accepted beat.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         // A presented beat that was not taken holds as it is.
         if (req_ch.valid) begin
            void'(pending_beats.pop_front());
         end
         if (pending_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_ch.valid        <= 1'b1;
            req_ch.base_sample  <= pending_beats[0].base_s;
            req_ch.new_sample   <= pending_beats[0].new_s;
            req_ch.canvas_alpha <= pending_beats[0].base_a;
            req_ch.ref_alpha    <= pending_beats[0].new_a;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Monitor: predict on request beats, check on response beats.
   always @(posedge clock) begin
      sample_beat_type    beat;
      logic signed [31:0] want;
      req_taken <= req_ch.valid && req_ch.ready;
      if (!reset) begin
         cycles <= cycles + 1;
         if (req_ch.valid && req_ch.ready) begin
            beat = '{req_ch.base_sample, req_ch.new_sample,
                     req_ch.canvas_alpha, req_ch.ref_alpha};
            expected_blend.push_back(blend_sample(beat));
            beats_sent <= beats_sent + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            beats_checked <= beats_checked + 1;
            if (expected_blend.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("unexpected beat: blended_sample=%h", rsp_ch.blended_sample);
            end else begin
               want = expected_blend.pop_front();
               if (want !== rsp_ch.blended_sample) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display({"mismatch: mode=%0d clamp=%0d premul=%0d alpha_ch=%0d",
                               " plane=%0d exp=%h got=%h"},
                              cfg_mode, cfg_clamp, cfg_premul, cfg_is_alpha,
                              cfg_has_alpha, want, rsp_ch.blended_sample);
               end
            end
         end
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.base_sample  = '0;
      req_ch.new_sample   = '0;
      req_ch.canvas_alpha = '0;
      req_ch.ref_alpha    = '0;
      rsp_ch.ready = 1'b0;
   end

   task automatic write_reg(input logic [pbl_pkg::CSR_IDX_W-1:0] idx, input logic [2:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         pbl_pkg::REG_BLEND_MODE:    cfg_mode      = val;
         pbl_pkg::REG_CLAMP_ENABLE:  cfg_clamp     = val[0];
         pbl_pkg::REG_PREMULTIPLIED: cfg_premul    = val[0];
         pbl_pkg::REG_CHANNEL_ALPHA: cfg_is_alpha  = val[0];
         pbl_pkg::REG_ALPHA_PRESENT: cfg_has_alpha = val[0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [2:0] mode, input logic clampv, input logic premul,
                            input logic is_alpha, input logic plane);
      write_reg(pbl_pkg::REG_BLEND_MODE, mode);
      write_reg(pbl_pkg::REG_CLAMP_ENABLE, {2'b00, clampv});
      write_reg(pbl_pkg::REG_PREMULTIPLIED, {2'b00, premul});
      write_reg(pbl_pkg::REG_CHANNEL_ALPHA, {2'b00, is_alpha});
      write_reg(pbl_pkg::REG_ALPHA_PRESENT, {2'b00, plane});
   endtask

   // Wait for the pipe to drain before touching the registers.
   task automatic drain();
      while (pending_beats.size() > 0 || expected_blend.size() > 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Values biased toward the interesting region around 0..1.0 and the rails.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(32'h0100_0000);
         2: return 32'sh0100_0000 + $signed($urandom_range(64)) - 32;
         3: return -$signed($urandom_range(32'h0200_0000));
         4: return ($urandom_range(1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return $signed({{8{1'b0}}, 24'($urandom)}) - 32'sh0080_0000;
      endcase
   endfunction

   task automatic queue_beat(input logic signed [31:0] b, input logic signed [31:0] n,
                             input logic signed [31:0] ba, input logic signed [31:0] na);
      sample_beat_type s;
      s = '{b, n, ba, na};
      pending_beats.push_back(s);
   endtask

   initial begin
      int phase;
      cfg_mode = pbl_pkg::MODE_NONE; cfg_clamp = 1'b0; cfg_premul = 1'b0;
      cfg_is_alpha = 1'b0; cfg_has_alpha = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: rails, unit alpha, zero coverage, every mode in one setting.
      write_all(pbl_pkg::MODE_BLEND_ABOVE, 1'b0, 1'b0, 1'b0, 1'b1);
      queue_beat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      queue_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_beat(32'h0100_0000, 32'h0080_0000, 0, 0);
      queue_beat(32'h0100_0000, 32'h0080_0000, 32'h0100_0000, 32'h0100_0000);
      queue_beat(32'h0080_0000, 32'h0040_0000, 32'h0200_0000, 32'h0200_0000);
      queue_beat(32'h0123_4567, 32'hfedc_ba98, 32'h0080_0000, 32'h0040_0000);
      drain();
      for (int m = 0; m < 8; m++) begin
         write_reg(pbl_pkg::REG_BLEND_MODE, m[2:0]);
         queue_beat(32'h7fff_ffff, 32'h0100_0000, 32'h0080_0000, 32'hffff_0000);
         queue_beat(32'h8000_0000, 32'h7fff_ffff, 32'h0100_0000, 32'h0180_0000);
         drain();
      end
      write_all(pbl_pkg::MODE_NONE, 1'b0, 1'b0, 1'b0, 1'b0);

      // Random: phases of register settings crossed with idling patterns.
      for (phase = 0; phase < 26; phase++) begin
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 70; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 70; end
            default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
         endcase
         if (phase == 25) write_all(pbl_pkg::MODE_MULADD_BELOW, 1'b1, 1'b1, 1'b1, 1'b1);
         else write_all(3'($urandom_range(7)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), ($urandom_range(3) == 0),
                        ($urandom_range(3) != 0));
         for (int i = 0; i < 50; i++)
            queue_beat(pick_value(), pick_value(), pick_value(), pick_value());
         drain();
      end

      $display("covered %0d sample beats, %0d checked, over 26 register settings",
               beats_sent, beats_checked);
      $display("all eight modes, clamp, premultiplied/straight, alpha channel, plane off");
      if (mismatches == 0 && expected_blend.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

/* patch_sample_blender.f */
hw/rtl/pbl_pkg.sv
hw/rtl/pbl_req_if.sv
hw/rtl/pbl_rsp_if.sv
hw/rtl/pbl_div.sv
hw/rtl/patch_sample_blender.sv
tb/tb.sv
